// File: rtl/buddy_block_allocator_macros.svh
// Assertion macros used by the allocator engine RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

// File: rtl/bba_pkg.sv
// Shared constants, status codes and the front-to-back command type.
`timescale 1ns / 1ps
package bba_pkg;
    localparam int HEAP_BITS      = 16;
    localparam int MIN_BLOCK_BITS = 5;
    localparam int LEVEL_COUNT    = 12;

    localparam int NODE_W      = LEVEL_COUNT;
    localparam int LVL_W       = 4;
    localparam int ENTRY_W     = 5;
    localparam int STORE_AW    = LEVEL_COUNT - 1;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int WSEL_W      = 5;
    localparam int WORD_W      = 1 << WSEL_W;
    localparam int WORD_AW     = NODE_W - WSEL_W;
    localparam int WORD_DEPTH  = 1 << WORD_AW;
    localparam int TOP_LEVELS  = WSEL_W;

    localparam logic [LVL_W-1:0]   LVL_MAX   = LVL_W'(LEVEL_COUNT - 1);
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = ENTRY_W'(LEVEL_COUNT);

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic             is_free;
        logic             too_big;
        logic             bad_off;
        logic [LVL_W-1:0] target;
        logic [15:0]      off;
    } t_cmd;
endpackage

// File: rtl/buddy_block_allocator.sv
// Buddy allocator over a 64 KiB heap with 32-byte minimum blocks, twelve levels.
// Input channel: drive op, request_bytes and block_offset with i_push; a
//   transaction is taken when i_push is high and o_full is low. A two-entry
//   queue holds classified requests ahead of the engine.
// Result channel: while o_empty is low, o_status, o_granted_offset and
//   o_granted_level show the oldest result; i_pop takes it. One result per request.
// Order of work, from acceptance with the engine idle: rejects (oversize,
//   misaligned) are answered from the idle state. An allocate scans the levels,
//   reads the word RAM when the search goes there, then makes its tree writes:
//   one write clears the chosen block and one more is made per split.
//   A free reads the level store, then merges step by step; an unknown offset is rejected.
// Each tree write is a read-modify-write on the free-bit word RAM, which sets
//   the pace; one request is in the engine at a time.
// Reset: synchronous, active low. Afterwards a pass zeroes all 2048 entries of the
//   level store; o_full stays high until it ends. Only the root block starts free.
// When the result is not popped the engine holds before its next request;
//   the queue keeps taking transactions until it is full.
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [31:0] i_request_bytes,
    input  logic [15:0] i_block_offset,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_offset,
    output logic [3:0]  o_granted_level
);
    logic cmd_vld, cmd_rdy, clearing;
    t_cmd cmd;

    bba_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_hold          (clearing),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .i_block_offset  (i_block_offset),
        .o_full          (o_full),
        .o_cmd_vld       (cmd_vld),
        .o_cmd           (cmd),
        .i_cmd_rdy       (cmd_rdy)
    );

    bba_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_vld        (cmd_vld),
        .i_cmd            (cmd),
        .o_cmd_rdy        (cmd_rdy),
        .o_clearing       (clearing),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_granted_level  (o_granted_level)
    );
endmodule

// File: rtl/bba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bba_front.sv
// Request intake: classifies each transaction and queues it for the engine.
`timescale 1ns / 1ps
module bba_front import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_hold,
    input  logic        i_op,
    input  logic [31:0] i_request_bytes,
    input  logic [15:0] i_block_offset,
    output logic        o_full,
    output logic        o_cmd_vld,
    output t_cmd        o_cmd,
    input  logic        i_cmd_rdy
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, pop_ok;
    t_cmd       cls;

    always_comb begin
        logic [LVL_W-1:0] t;
        t = '0;
        // deepest level whose block still holds the request
        for (int l = 1; l < LEVEL_COUNT; l++) begin
            if ({1'b0, i_request_bytes} <= (33'd1 << (HEAP_BITS - l))) begin
                t = t + 1'b1;
            end
        end
        cls.is_free = i_op;
        cls.too_big = (i_request_bytes[31:17] != '0) ||
                      (i_request_bytes[16] && (i_request_bytes[15:0] != '0));
        cls.bad_off = (i_block_offset[MIN_BLOCK_BITS-1:0] != '0);
        cls.target  = t;
        cls.off     = i_block_offset;
    end

    assign o_full    = (r_cnt == 2'd2) || i_hold;
    assign push_ok   = i_push && !o_full;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign pop_ok    = o_cmd_vld && i_cmd_rdy;
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
    end
endmodule

// File: rtl/bba_back.sv
// Allocation engine: free-bit tree search, split, merge and the result register.
`timescale 1ns / 1ps
`include "buddy_block_allocator_macros.svh"
module bba_back import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_vld,
    input  t_cmd        i_cmd,
    output logic        o_cmd_rdy,
    output logic        o_clearing,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_offset,
    output logic [3:0]  o_granted_level
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_FIND = 4'd3;
    localparam logic [3:0] S_WA   = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_MA   = 4'd7;
    localparam logic [3:0] S_MB   = 4'd8;

    localparam logic [STORE_AW-1:0] CLR_LAST = '1;

    logic [3:0]            r_state, n_state;
    logic [LVL_W-1:0]      r_lvl, n_lvl, r_tgt, n_tgt, r_orig, n_orig;
    logic [NODE_W-1:0]     r_node, n_node, r_wnode, n_wnode;
    logic                  r_wset, n_wset;
    logic [15:0]           r_off, n_off;
    logic [STORE_AW-1:0]   r_clr, n_clr;
    logic [WORD_W-1:0]     r_top;
    logic [WORD_DEPTH-1:0] r_nz;
    logic                  r_out_vld, n_out_vld;
    logic [1:0]            r_st, n_st;
    logic [15:0]           r_goff, n_goff;
    logic [3:0]            r_glvl, n_glvl;

    logic [WORD_AW-1:0]    fr_raddr, widx;
    logic [WORD_W-1:0]     fr_rdata, cur_word, w_new;
    logic                  wr_en;
    logic                  st_we;
    logic [STORE_AW-1:0]   st_waddr;
    logic [ENTRY_W-1:0]    st_wdata, st_rdata;
    logic                  cmd_take;

    function automatic logic [WORD_W-1:0] top_mask(input logic [LVL_W-1:0] lvl);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 1; i < WORD_W; i++) begin
            m[i] = ((32'(i) >> lvl) == 32'd1);
        end
        return m;
    endfunction

    function automatic logic [WORD_DEPTH-1:0] word_mask(input logic [LVL_W-1:0] lvl);
        logic [WORD_DEPTH-1:0] m;
        logic [LVL_W-1:0]      sh;
        m  = '0;
        sh = lvl - LVL_W'(TOP_LEVELS);
        for (int i = 1; i < WORD_DEPTH; i++) begin
            m[i] = (lvl >= LVL_W'(TOP_LEVELS)) && ((32'(i) >> sh) == 32'd1);
        end
        return m;
    endfunction

    function automatic logic [WSEL_W-1:0] pe_word(input logic [WORD_W-1:0] v);
        logic [WSEL_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) idx = WSEL_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [WORD_AW-1:0] pe_flags(input logic [WORD_DEPTH-1:0] v);
        logic [WORD_AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_DEPTH; i++) begin
            if (v[i]) idx = WORD_AW'(i);
        end
        return idx;
    endfunction

    bba_ram #(.WIDTH(WORD_W), .DEPTH(WORD_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en && (widx != '0)),
        .i_waddr (widx),
        .i_wdata (w_new),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    bba_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (i_cmd.off[15:MIN_BLOCK_BITS]),
        .o_rdata (st_rdata)
    );

    assign widx      = r_wnode[NODE_W-1:WSEL_W];
    // words that were never written, or emptied, read as all clear
    assign cur_word  = (widx == '0) ? r_top : (r_nz[widx] ? fr_rdata : '0);
    assign o_cmd_rdy = (r_state == S_IDLE) && !r_out_vld;
    assign cmd_take  = o_cmd_rdy && i_cmd_vld;
    assign o_clearing = (r_state == S_CLR);

    always_comb begin
        logic [WORD_W-1:0]     tm;
        logic [WORD_DEPTH-1:0] wm;
        logic [WORD_AW-1:0]    w;
        logic [NODE_W-1:0]     bud;
        logic [27:0]           sh_off;
        logic [16:0]           sh_node;
        logic [ENTRY_W-1:0]    sh_amt;

        n_state   = r_state;
        n_lvl     = r_lvl;
        n_tgt     = r_tgt;
        n_orig    = r_orig;
        n_node    = r_node;
        n_wnode   = r_wnode;
        n_wset    = r_wset;
        n_off     = r_off;
        n_clr     = r_clr;
        n_out_vld = r_out_vld && !i_pop;
        n_st      = r_st;
        n_goff    = r_goff;
        n_glvl    = r_glvl;
        fr_raddr  = widx;
        wr_en     = 1'b0;
        w_new     = cur_word;
        st_we     = 1'b0;
        st_waddr  = r_clr;
        st_wdata  = '0;
        tm        = r_top & top_mask(r_lvl);
        wm        = r_nz & word_mask(r_lvl);
        w         = pe_flags(wm);
        bud       = r_wnode ^ NODE_W'(1);
        sh_off    = {r_node, 16'd0} >> r_lvl;
        sh_amt    = ENTRY_W'(HEAP_BITS) - {1'b0, r_lvl};
        sh_node   = {1'b1, r_off} >> sh_amt;

        unique case (r_state)
            S_CLR: begin
                st_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_take) begin
                    n_off = i_cmd.off;
                    priority if (i_cmd.is_free && i_cmd.bad_off) begin
                        n_out_vld = 1'b1;
                        n_st      = ST_BAD_FREE;
                        n_goff    = '0;
                        n_glvl    = '0;
                    end else if (i_cmd.is_free) begin
                        n_state = S_FCHK;
                    end else if (i_cmd.too_big) begin
                        n_out_vld = 1'b1;
                        n_st      = ST_TOO_BIG;
                        n_goff    = '0;
                        n_glvl    = '0;
                    end else begin
                        n_lvl   = i_cmd.target;
                        n_tgt   = i_cmd.target;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // walk up from the target level until one has a free block
                priority if (tm != '0) begin
                    n_node  = NODE_W'(pe_word(tm));
                    n_wnode = NODE_W'(pe_word(tm));
                    n_wset  = 1'b0;
                    n_state = S_WA;
                end else if (wm != '0) begin
                    fr_raddr = w;
                    n_wnode  = {w, {WSEL_W{1'b0}}};
                    n_state  = S_FIND;
                end else if (r_lvl == '0) begin
                    n_out_vld = 1'b1;
                    n_st      = ST_NO_FREE;
                    n_goff    = '0;
                    n_glvl    = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            S_FIND: begin
                n_node  = {widx, pe_word(fr_rdata)};
                n_wnode = {widx, pe_word(fr_rdata)};
                n_wset  = 1'b0;
                n_state = S_WA;
            end
            S_WA: begin
                n_state = S_WB;
            end
            S_WB: begin
                wr_en = 1'b1;
                w_new = r_wset ? (cur_word | (WORD_W'(1) << r_wnode[WSEL_W-1:0]))
                               : (cur_word & ~(WORD_W'(1) << r_wnode[WSEL_W-1:0]));
                if (r_lvl < r_tgt) begin
                    // split: left child stays free, descend into the right one
                    n_wnode = {r_node[NODE_W-2:0], 1'b0};
                    n_node  = {r_node[NODE_W-2:0], 1'b1};
                    n_wset  = 1'b1;
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_WA;
                end else begin
                    st_we     = 1'b1;
                    st_waddr  = sh_off[15:MIN_BLOCK_BITS];
                    st_wdata  = ENTRY_W'(r_lvl) + ENTRY_W'(1);
                    n_out_vld = 1'b1;
                    n_st      = ST_DONE;
                    n_goff    = sh_off[15:0];
                    n_glvl    = r_lvl;
                    n_state   = S_IDLE;
                end
            end
            S_FCHK: begin
                if ((st_rdata == '0) || (st_rdata > ENTRY_MAX)) begin
                    n_out_vld = 1'b1;
                    n_st      = ST_BAD_FREE;
                    n_goff    = '0;
                    n_glvl    = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_lvl   = LVL_W'(st_rdata - ENTRY_W'(1));
                    n_orig  = LVL_W'(st_rdata - ENTRY_W'(1));
                    st_we   = 1'b1;
                    st_waddr = r_off[15:MIN_BLOCK_BITS];
                    n_state = S_MA;
                end
            end
            S_MA: begin
                // first pass: node index from the offset at the block's level; fetch its word
                if (r_lvl == r_orig) begin
                    n_wnode  = sh_node[NODE_W-1:0];
                    fr_raddr = sh_node[NODE_W-1:WSEL_W];
                end
                n_state = S_MB;
            end
            S_MB: begin
                wr_en = 1'b1;
                if ((r_lvl != '0) && cur_word[bud[WSEL_W-1:0]]) begin
                    // merge: drop the buddy and move up to the parent
                    w_new   = cur_word & ~(WORD_W'(1) << bud[WSEL_W-1:0]);
                    n_wnode = r_wnode >> 1;
                    n_lvl   = r_lvl - 1'b1;
                    n_orig  = r_orig;
                    n_state = S_MA;
                end else begin
                    w_new     = cur_word | (WORD_W'(1) << r_wnode[WSEL_W-1:0]);
                    n_out_vld = 1'b1;
                    n_st      = ST_DONE;
                    n_goff    = '0;
                    n_glvl    = r_orig;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
            r_top     <= WORD_W'(2);
            r_nz      <= '0;
            r_lvl     <= '0;
            r_tgt     <= '0;
            r_orig    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
            r_lvl     <= n_lvl;
            r_tgt     <= n_tgt;
            r_orig    <= n_orig;
            if (wr_en) begin
                if (widx == '0) begin
                    r_top <= w_new;
                end else begin
                    r_nz[widx] <= (w_new != '0);
                end
            end
        end
        r_node  <= n_node;
        r_wnode <= n_wnode;
        r_wset  <= n_wset;
        r_off   <= n_off;
        r_st    <= n_st;
        r_goff  <= n_goff;
        r_glvl  <= n_glvl;
    end

    assign o_empty          = !r_out_vld;
    assign o_status         = r_st;
    assign o_granted_offset = r_goff;
    assign o_granted_level  = r_glvl;

    `BBA_ASSERT_IMP(a_busy_out_empty, i_clk, i_rst_n, (r_state != S_IDLE) && (r_state != S_CLR), !r_out_vld)
    `BBA_ASSERT_IMP(a_lvl_range, i_clk, i_rst_n, 1'b1, (r_lvl <= LVL_MAX) && (r_tgt <= LVL_MAX))
    `BBA_ASSERT_NXT(a_clr_done, i_clk, i_rst_n, (r_state == S_CLR) && (r_clr == CLR_LAST), r_state == S_IDLE)
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps
module tb_top;
    import bba_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam int   SPLIT_LEVEL = LEVEL_COUNT - 1;

    typedef struct {
        logic        op;
        logic [31:0] bytes;
        logic [15:0] off;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] off;
        logic [3:0]  lvl;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_op = 1'b0;
    logic [31:0] i_request_bytes = '0;
    logic [15:0] i_block_offset = '0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty;
    logic [1:0]  o_status;
    logic [15:0] o_granted_offset;
    logic [3:0]  o_granted_level;

    buddy_block_allocator DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    bit         tree_free [1 << LEVEL_COUNT];
    logic [4:0] level_tag [STORE_DEPTH];
    logic [15:0] live_blocks[$];

    t_req   pending_reqs[$];
    t_grant expected_grants[$];
    int     error_count = 0;
    bit     quiet = 0;
    bit     hold_push = 0;
    int     push_gap = 0;
    int     pop_gap = 0;
    logic   accepted_last = 1'b0;

    function automatic t_grant alloc_predict(logic [31:0] bytes);
        t_grant g;
        longint blk;
        int target, lvl, node, found;
        g = '{ST_DONE, 16'd0, 4'd0};
        blk = longint'(1) << HEAP_BITS;
        if (longint'(bytes) > blk) begin
            g.status = ST_TOO_BIG;
            return g;
        end
        target = 0;
        while (target < SPLIT_LEVEL && longint'(bytes) <= (blk >> 1)) begin
            target++;
            blk >>= 1;
        end
        found = -1;
        node = 0;
        for (lvl = target; lvl >= 0 && found < 0; lvl--)
            for (int n = (2 << lvl) - 1; n >= (1 << lvl); n--)
                if (tree_free[n]) begin
                    node = n;
                    found = lvl;
                    break;
                end
        if (found < 0) begin
            g.status = ST_NO_FREE;
            return g;
        end
        lvl = found;
        tree_free[node] = 0;
        while (lvl < target) begin
            tree_free[node << 1] = 1;
            node = (node << 1) | 1;
            lvl++;
        end
        g.off = 16'((node - (1 << lvl)) << (HEAP_BITS - lvl));
        g.lvl = 4'(lvl);
        level_tag[g.off >> MIN_BLOCK_BITS] = 5'(lvl + 1);
        return g;
    endfunction

    function automatic t_grant free_predict(logic [15:0] off);
        t_grant g;
        int idx, lvl, node;
        g = '{ST_BAD_FREE, 16'd0, 4'd0};
        idx = off >> MIN_BLOCK_BITS;
        if (off[MIN_BLOCK_BITS-1:0] != 0) return g;
        if (level_tag[idx] == 0 || level_tag[idx] > LEVEL_COUNT) return g;
        lvl = level_tag[idx] - 1;
        if ((off >> (HEAP_BITS - lvl)) >= (1 << lvl)) return g;
        node = (1 << lvl) + (off >> (HEAP_BITS - lvl));
        g = '{ST_DONE, 16'd0, 4'(lvl)};
        level_tag[idx] = 0;
        tree_free[node] = 1;
        while (lvl > 0 && tree_free[node ^ 1]) begin
            tree_free[node] = 0;
            tree_free[node ^ 1] = 0;
            node >>= 1;
            lvl--;
            tree_free[node] = 1;
        end
        return g;
    endfunction

    function automatic logic [31:0] random_bytes();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'($urandom_range(0, 65536));
            2: return 32'(1) << $urandom_range(MIN_BLOCK_BITS, HEAP_BITS);
            default: return 32'($urandom_range(0, 2048));
        endcase
    endfunction

    function automatic logic [15:0] random_free_offset();
        int k;
        if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            return live_blocks[k];
        end
        return 16'($urandom());
    endfunction

    task automatic queue_req(logic op, logic [31:0] bytes, logic [15:0] off);
        pending_reqs.push_back('{op, bytes, off});
    endtask

    // Driver: present requests at the falling edge; hold until accepted.
    always @(negedge i_clk) begin
        if (!i_push || accepted_last) begin
            if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                i_push <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_push) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_op <= r.op;
                i_request_bytes <= r.bytes;
                i_block_offset <= r.off;
                i_push <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) push_gap <= $urandom_range(1, 8);
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Accept side: predict on each accepted transaction.
    always @(posedge i_clk) begin
        accepted_last <= 1'b0;
        if (i_rst_n && i_push && !o_full) begin
            t_grant g;
            accepted_last <= 1'b1;
            if (i_op == OP_ALLOC) begin
                g = alloc_predict(i_request_bytes);
                if (g.status == ST_DONE) live_blocks.push_back(g.off);
            end else begin
                g = free_predict(i_block_offset);
                if (g.status == ST_DONE)
                    foreach (live_blocks[k])
                        if (live_blocks[k] == i_block_offset) begin
                            live_blocks.delete(k);
                            break;
                        end
            end
            expected_grants.push_back(g);
        end
    end

    // Monitor: check each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result status=%0d off=%0h lvl=%0d",
                         $time, o_status, o_granted_offset, o_granted_level);
                error_count++;
            end else begin
                t_grant e;
                e = expected_grants.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    error_count++;
                end
                if (o_granted_offset !== e.off) begin
                    $display("%0t: offset expected %0h actual %0h",
                             $time, e.off, o_granted_offset);
                    error_count++;
                end
                if (o_granted_level !== e.lvl) begin
                    $display("%0t: level expected %0d actual %0d",
                             $time, e.lvl, o_granted_level);
                    error_count++;
                end
            end
        end
    end

    // Pop pacing at the falling edge, with random stall bursts.
    always @(negedge i_clk) begin
        if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            i_pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            pop_gap <= $urandom_range(0, 7);
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    initial begin
        for (int n = 0; n < (1 << LEVEL_COUNT); n++) tree_free[n] = 0;
        tree_free[1] = 1;
        for (int k = 0; k < STORE_DEPTH; k++) level_tag[k] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: extremes, oversize, zero size, exhaustion, bad frees
        queue_req(OP_ALLOC, 32'd65537, 16'hFFFF);
        queue_req(OP_ALLOC, 32'hFFFF_FFFF, 16'h0);
        queue_req(OP_ALLOC, 32'd0, 16'h0);
        queue_req(OP_FREE, 32'hFFFF_FFFF, 16'hFFE0);
        queue_req(OP_FREE, 32'h0, 16'hFFE0);
        queue_req(OP_FREE, 32'h0, 16'h0001);
        queue_req(OP_FREE, 32'h0, 16'h0000);
        queue_req(OP_ALLOC, 32'd65536, 16'h0);
        queue_req(OP_ALLOC, 32'd1, 16'h0);
        queue_req(OP_FREE, 32'h0, 16'h0000);
        queue_req(OP_FREE, 32'h0, 16'h0000);
        queue_req(OP_ALLOC, 32'd32768, 16'h0);
        queue_req(OP_ALLOC, 32'd32769, 16'h0);
        queue_req(OP_ALLOC, 32'd32768, 16'h0);
        queue_req(OP_ALLOC, 32'd32, 16'h0);
        queue_req(OP_FREE, 32'h0, 16'h8000);
        queue_req(OP_FREE, 32'h0, 16'h0000);
        queue_req(OP_ALLOC, 32'd33, 16'h0);
        queue_req(OP_FREE, 32'h0, 16'hFFC0);
        queue_req(OP_FREE, 32'h0, 16'h8000);

        // wait until the pipe drains, then pause the sender
        wait (pending_reqs.size() == 0 && !i_push && expected_grants.size() == 0);
        hold_push = 1;
        repeat (50) @(posedge i_clk);
        hold_push = 0;

        // random part: allocs/frees of live blocks, with noise
        for (int k = 0; k < 1730; k++) begin
            if (k == 1500) begin
                wait (pending_reqs.size() == 0);
                quiet = 1;
            end
            if ($urandom_range(0, 1))
                queue_req(OP_ALLOC, random_bytes(), 16'($urandom()));
            else
                queue_req(OP_FREE, $urandom(), random_free_offset());
            if (pending_reqs.size() > 4) wait (pending_reqs.size() <= 4);
        end
        wait (pending_reqs.size() == 0 && !i_push);
        wait (expected_grants.size() == 0);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_grants.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
